### rtl/core/sops_pkg.sv
// Shared types, constants and helpers for the sum-of-pairs alignment scorer.
// No dependencies; used by sum_of_pairs_alignment_score.
package sops_pkg;

  localparam int FREQ_W = 24;
  localparam int ACC_W  = 48;
  localparam int TOT_W  = 56;
  localparam int MAG_W  = 24;
  localparam int MUL_A_W = 32;
  localparam int MUL_Y_W = MUL_A_W + MAG_W;
  localparam int GAP_TYPES = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEQ  = 1'b1;

  localparam logic [1:0] GT_LL = 2'd0;
  localparam logic [1:0] GT_LG = 2'd1;
  localparam logic [1:0] GT_GL = 2'd2;
  localparam logic [1:0] GT_GG = 2'd3;

  localparam logic [0:0] REG_GAP_OPEN    = 1'b0;
  localparam logic [0:0] REG_GAP_PARTIAL = 1'b1;

  localparam logic signed [15:0] GAP_OPEN_RST    = -16'sd768;
  localparam logic signed [15:0] GAP_PARTIAL_RST = -16'sd154;

  localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [TOT_W-1:0] MAX56 = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] MIN56 = {1'b1, {(TOT_W-1){1'b0}}};

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_SELF_WW = 14'b00000000000010,
    ST_LO      = 14'b00000000000100,
    ST_HI      = 14'b00000000001000,
    ST_SAT     = 14'b00000000010000,
    ST_ACC1    = 14'b00000000100000,
    ST_ACC2    = 14'b00000001000000,
    ST_ROW     = 14'b00000010000000,
    ST_PAIR    = 14'b00000100000000,
    ST_PMUL    = 14'b00001000000000,
    ST_SUB     = 14'b00010000000000,
    ST_COL     = 14'b00100000000000,
    ST_TOT     = 14'b01000000000000,
    ST_OUT     = 14'b10000000000000
  } state_t;

  // Gap-type penalty table: symmetric, zero on the diagonal.
  function automatic logic signed [15:0] gap_entry(input logic [1:0] a, input logic [1:0] b,
                                                   input logic signed [15:0] g_open,
                                                   input logic signed [15:0] g_part);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ((lo == GT_LL && hi == GT_LG) || (lo == GT_LG && hi == GT_GL)) begin
      return g_open;
    end else if (lo == GT_LG && hi == GT_GG) begin
      return g_part;
    end
    return 16'sd0;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W+1:0] v);
    if (v > $signed({{2{MAX48[ACC_W-1]}}, MAX48})) begin
      return MAX48;
    end else if (v < $signed({{2{MIN48[ACC_W-1]}}, MIN48})) begin
      return MIN48;
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

### rtl/core/sum_of_pairs_alignment_score.sv
// Top level of the weighted sum-of-pairs column scorer.
// Depends on sops_pkg and sops_ram (substitution table).
//
// Channel | Dir | Handshake            | Content
// in_     | in  | in_tvalid/in_tready  | tuser=command, tdata=fields, tlast=end_of_column
// out_    | out | out_tvalid/out_tready| tdata=column_score,half_total, tlast=final_res
// cfg_    | in  | cfg_we               | register index and 16-bit value
//
// A load item is taken while idle. A sequence item updates the frequencies and, when it
// carries a scored letter, adds its self term. A column end walks every letter pair and
// then every gap-type pair through the one shared 32x24 multiplier, row by row, counting
// off-diagonal pairs twice.
// Reset clears frequencies, sums and the total and presets the gap registers; the table
// holds garbage until loaded. A stalled result holds in the output register; the next item waits.
module sum_of_pairs_alignment_score #(
  parameter int ALPHABET_SIZE = 20,
  parameter int SCORE_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: row_letter[4:0], col_letter[9:5], entry_value[25:10], letter[30:26],
  // gap_here[31], gap_before[32], weight[48:33], end_of_alignment[49], zero fill
  input  logic [55:0] in_tdata,
  // tuser: command
  input  logic [0:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: column_score[47:0], half_total[95:48]
  output logic [95:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IW    = $clog2(ALPHABET_SIZE);
  localparam int DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = sops_pkg::FREQ_W;
  localparam int ACW   = sops_pkg::ACC_W;
  localparam int MW    = sops_pkg::MAG_W;
  localparam logic [IW-1:0] LAST_LETTER = IW'(ALPHABET_SIZE - 1);
  localparam logic [IW-1:0] LAST_GAP    = IW'(sops_pkg::GAP_TYPES - 1);
  localparam logic signed [24:0] LIM_HI = 25'((1 << (SCORE_BITS - 1)) - 1);
  localparam logic signed [24:0] LIM_LO = -LIM_HI - 25'sd1;

  // Input fields
  logic [4:0]         in_row, in_col, in_letter;
  logic signed [15:0] in_entry;
  logic               in_gh, in_gb, in_eoa;
  logic [15:0]        in_weight;
  assign in_row    = in_tdata[4:0];
  assign in_col    = in_tdata[9:5];
  assign in_entry  = in_tdata[25:10];
  assign in_letter = in_tdata[30:26];
  assign in_gh     = in_tdata[31];
  assign in_gb     = in_tdata[32];
  assign in_weight = in_tdata[48:33];
  assign in_eoa    = in_tdata[49];

  sops_pkg::state_t state_r, state_nxt;
  logic signed [15:0]       gap_open_r, gap_part_r;
  logic [FW-1:0]            lfreq_r [ALPHABET_SIZE];
  logic [FW-1:0]            lfreq_nxt [ALPHABET_SIZE];
  logic [FW-1:0]            gfreq_r [sops_pkg::GAP_TYPES];
  logic [FW-1:0]            gfreq_nxt [sops_pkg::GAP_TYPES];
  logic signed [ACW-1:0]    self_r, self_nxt, acc_r, acc_nxt, col_r, col_nxt;
  logic signed [ACW-1:0]    term_r, term_nxt;
  logic signed [sops_pkg::TOT_W-1:0] total_r, total_nxt;
  logic [15:0]              w_r, w_nxt;
  logic                     eoc_r, eoc_nxt, eoa_r, eoa_nxt;
  logic                     self_mode_r, self_mode_nxt, gap_mode_r, gap_mode_nxt;
  logic                     diag_r, diag_nxt;
  logic [IW-1:0]            i_r, i_nxt, j_r, j_nxt;
  logic [FW-1:0]            fi_r, fi_nxt;
  logic [2*FW-1:0]          p_r, p_nxt;
  logic signed [MW-1:0]     m_r, m_nxt;
  logic [sops_pkg::MUL_Y_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic                     out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [95:0]              out_data_r, out_data_nxt;

  // Shared multiplier and shared saturating adder
  logic [sops_pkg::MUL_A_W-1:0] mul_a;
  logic [MW-1:0]                mul_b;
  logic [sops_pkg::MUL_Y_W-1:0] mul_y;
  logic signed [ACW:0]          add_a, add_b;
  logic signed [ACW-1:0]        add_y;
  assign mul_y = sops_pkg::MUL_Y_W'(mul_a) * sops_pkg::MUL_Y_W'(mul_b);
  assign add_y = sops_pkg::sat48(ACW'(0) + {add_a[ACW], add_a} + {add_b[ACW], add_b});

  logic          m_neg;
  logic [MW-1:0] m_mag;
  assign m_neg = m_r[MW-1];
  assign m_mag = m_neg ? MW'(-m_r) : MW'(m_r);

  // Table RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [SCORE_BITS-1:0] ram_wdata, ram_rdata;
  logic signed [24:0]    entry_ext;

  sops_ram #(.WIDTH(SCORE_BITS), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          accept, letter_ok;
  logic [1:0]    gtype;
  logic [IW-1:0] lidx, fidx;
  logic [FW-1:0] lf_sel, gf_sel, f_sel;
  logic [FW:0]   lf_sum, gf_sum;
  logic [79:0]   prod;
  logic [IW-1:0] last_idx;
  logic signed [sops_pkg::TOT_W:0] tot_sum;
  logic signed [sops_pkg::TOT_W-1:0] half_full;
  logic signed [ACW-1:0] half48;

  assign in_tready = (state_r == sops_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign letter_ok = !in_gh && ({1'b0, in_letter} < 6'(ALPHABET_SIZE));
  assign gtype     = {in_gb, in_gh};
  assign lidx      = in_letter[IW-1:0];
  assign last_idx  = gap_mode_r ? LAST_GAP : LAST_LETTER;

  // One read index into the frequency arrays: the input letter while idle (the gap
  // array then uses the gap type), row index at a row start, column index otherwise.
  always_comb begin
    if (state_r == sops_pkg::ST_IDLE) begin
      fidx = lidx;
    end else if (state_r == sops_pkg::ST_ROW) begin
      fidx = i_r;
    end else begin
      fidx = j_r;
    end
  end
  assign lf_sel = lfreq_r[fidx];
  assign gf_sel = (state_r == sops_pkg::ST_IDLE) ? gfreq_r[gtype] : gfreq_r[fidx[1:0]];
  assign f_sel  = gap_mode_r ? gf_sel : lf_sel;
  assign lf_sum = {1'b0, lf_sel} + (FW+1)'(in_weight);
  assign gf_sum = {1'b0, gf_sel} + (FW+1)'(in_weight);

  assign entry_ext = 25'(in_entry);
  assign ram_we    = accept && (in_tuser[0] == sops_pkg::CMD_LOAD) &&
                     ({1'b0, in_row} < 6'(ALPHABET_SIZE)) &&
                     ({1'b0, in_col} < 6'(ALPHABET_SIZE));
  assign ram_waddr = AW'(in_row) * AW'(ALPHABET_SIZE) + AW'(in_col);
  always_comb begin
    if (entry_ext > LIM_HI) begin
      ram_wdata = LIM_HI[SCORE_BITS-1:0];
    end else if (entry_ext < LIM_LO) begin
      ram_wdata = LIM_LO[SCORE_BITS-1:0];
    end else begin
      ram_wdata = entry_ext[SCORE_BITS-1:0];
    end
  end
  assign ram_raddr = (state_r == sops_pkg::ST_IDLE) ?
                     AW'(in_letter) * AW'(ALPHABET_SIZE) + AW'(in_letter) :
                     AW'(i_r) * AW'(ALPHABET_SIZE) + AW'(j_r);

  assign prod      = {hi_r, 24'd0} + 80'(lo_r);
  assign tot_sum   = {total_r[sops_pkg::TOT_W-1], total_r} + (sops_pkg::TOT_W+1)'(col_r);
  assign half_full = total_r >>> 1;
  assign half48    = (half_full > 56'(sops_pkg::MAX48)) ? sops_pkg::MAX48 :
                     (half_full < 56'(sops_pkg::MIN48)) ? sops_pkg::MIN48 :
                     half_full[ACW-1:0];

  always_comb begin
    state_nxt     = state_r;
    lfreq_nxt     = lfreq_r;
    gfreq_nxt     = gfreq_r;
    self_nxt      = self_r;
    acc_nxt       = acc_r;
    col_nxt       = col_r;
    term_nxt      = term_r;
    total_nxt     = total_r;
    w_nxt         = w_r;
    eoc_nxt       = eoc_r;
    eoa_nxt       = eoa_r;
    self_mode_nxt = self_mode_r;
    gap_mode_nxt  = gap_mode_r;
    diag_nxt      = diag_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    fi_nxt        = fi_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    add_a         = '0;
    add_b         = '0;

    case (state_r)
      sops_pkg::ST_IDLE: begin
        if (accept && in_tuser[0] == sops_pkg::CMD_SEQ) begin
          gfreq_nxt[gtype] = gf_sum[FW] ? {FW{1'b1}} : gf_sum[FW-1:0];
          if (letter_ok) begin
            lfreq_nxt[lidx] = lf_sum[FW] ? {FW{1'b1}} : lf_sum[FW-1:0];
          end
          w_nxt         = in_weight;
          eoc_nxt       = in_tlast;
          eoa_nxt       = in_eoa;
          self_mode_nxt = 1'b1;
          gap_mode_nxt  = 1'b0;
          i_nxt         = '0;
          if (letter_ok) begin
            state_nxt = sops_pkg::ST_SELF_WW;
          end else if (in_tlast) begin
            self_mode_nxt = 1'b0;
            state_nxt     = sops_pkg::ST_ROW;
          end
        end
      end
      sops_pkg::ST_SELF_WW: begin
        mul_a = sops_pkg::MUL_A_W'(w_r);
        mul_b = MW'(w_r);
        p_nxt = (2*FW)'(mul_y);
        m_nxt = MW'($signed(ram_rdata));
        state_nxt = sops_pkg::ST_LO;
      end
      sops_pkg::ST_ROW: begin
        fi_nxt    = f_sel;
        j_nxt     = i_r;
        diag_nxt  = 1'b1;
        state_nxt = sops_pkg::ST_PAIR;
      end
      sops_pkg::ST_PAIR: begin
        // RAM read of entry (i, j) was issued by the address mux this cycle.
        p_nxt     = {{FW{1'b0}}, f_sel};
        state_nxt = sops_pkg::ST_PMUL;
      end
      sops_pkg::ST_PMUL: begin
        mul_a = sops_pkg::MUL_A_W'(fi_r);
        mul_b = MW'(p_r[FW-1:0]);
        p_nxt = (2*FW)'(mul_y);
        if (gap_mode_r) begin
          m_nxt = MW'(sops_pkg::gap_entry(i_r[1:0], j_r[1:0], gap_open_r, gap_part_r));
        end else begin
          m_nxt = MW'($signed(ram_rdata));
        end
        state_nxt = sops_pkg::ST_LO;
      end
      sops_pkg::ST_LO: begin
        mul_a     = sops_pkg::MUL_A_W'(p_r[FW-1:0]);
        mul_b     = m_mag;
        lo_nxt    = mul_y;
        state_nxt = sops_pkg::ST_HI;
      end
      sops_pkg::ST_HI: begin
        mul_a     = sops_pkg::MUL_A_W'(p_r[2*FW-1:FW]);
        mul_b     = m_mag;
        hi_nxt    = mul_y;
        state_nxt = sops_pkg::ST_SAT;
      end
      sops_pkg::ST_SAT: begin
        // A zero product ignores the table value, even one never written.
        if (p_r == '0 || m_mag == '0) begin
          term_nxt = '0;
        end else if (prod > 80'(sops_pkg::MAX48)) begin
          term_nxt = m_neg ? sops_pkg::MIN48 : sops_pkg::MAX48;
        end else begin
          term_nxt = m_neg ? -$signed(prod[ACW-1:0]) : $signed(prod[ACW-1:0]);
        end
        state_nxt = sops_pkg::ST_ACC1;
      end
      sops_pkg::ST_ACC1, sops_pkg::ST_ACC2: begin
        add_b = {term_r[ACW-1], term_r};
        if (self_mode_r) begin
          add_a         = {self_r[ACW-1], self_r};
          self_nxt      = add_y;
          self_mode_nxt = 1'b0;
          state_nxt     = eoc_r ? sops_pkg::ST_ROW : sops_pkg::ST_IDLE;
        end else begin
          add_a   = {acc_r[ACW-1], acc_r};
          acc_nxt = add_y;
          if (state_r == sops_pkg::ST_ACC1 && !diag_r) begin
            // Off-diagonal pairs count twice, saturating after each add.
            state_nxt = sops_pkg::ST_ACC2;
          end else if (diag_r && i_r != '0) begin
            diag_nxt  = 1'b0;
            j_nxt     = '0;
            state_nxt = sops_pkg::ST_PAIR;
          end else if (!diag_r && j_r != i_r - 1'b1) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = sops_pkg::ST_PAIR;
          end else if (i_r != last_idx) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = sops_pkg::ST_ROW;
          end else begin
            state_nxt = gap_mode_r ? sops_pkg::ST_COL : sops_pkg::ST_SUB;
          end
        end
      end
      sops_pkg::ST_SUB: begin
        add_a        = {acc_r[ACW-1], acc_r};
        add_b        = -{self_r[ACW-1], self_r};
        col_nxt      = add_y;
        acc_nxt      = '0;
        gap_mode_nxt = 1'b1;
        i_nxt        = '0;
        j_nxt        = '0;
        state_nxt    = sops_pkg::ST_ROW;
      end
      sops_pkg::ST_COL: begin
        add_a     = {col_r[ACW-1], col_r};
        add_b     = {acc_r[ACW-1], acc_r};
        col_nxt   = add_y;
        state_nxt = sops_pkg::ST_TOT;
      end
      sops_pkg::ST_TOT: begin
        if (tot_sum > (sops_pkg::TOT_W+1)'(sops_pkg::MAX56)) begin
          total_nxt = sops_pkg::MAX56;
        end else if (tot_sum < (sops_pkg::TOT_W+1)'(sops_pkg::MIN56)) begin
          total_nxt = sops_pkg::MIN56;
        end else begin
          total_nxt = tot_sum[sops_pkg::TOT_W-1:0];
        end
        state_nxt = sops_pkg::ST_OUT;
      end
      sops_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = eoa_r;
          out_data_nxt  = {half48, col_r};
          for (int k = 0; k < ALPHABET_SIZE; k++) begin
            lfreq_nxt[k] = '0;
          end
          for (int k = 0; k < sops_pkg::GAP_TYPES; k++) begin
            gfreq_nxt[k] = '0;
          end
          self_nxt     = '0;
          acc_nxt      = '0;
          gap_mode_nxt = 1'b0;
          i_nxt        = '0;
          j_nxt        = '0;
          if (eoa_r) begin
            total_nxt = '0;
          end
          state_nxt = sops_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sops_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sops_pkg::ST_IDLE;
      gap_open_r  <= sops_pkg::GAP_OPEN_RST;
      gap_part_r  <= sops_pkg::GAP_PARTIAL_RST;
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        lfreq_r[k] <= '0;
      end
      for (int k = 0; k < sops_pkg::GAP_TYPES; k++) begin
        gfreq_r[k] <= '0;
      end
      self_r      <= '0;
      acc_r       <= '0;
      total_r     <= '0;
      self_mode_r <= 1'b0;
      gap_mode_r  <= 1'b0;
      diag_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      eoc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we && cfg_index == sops_pkg::REG_GAP_OPEN) begin
        gap_open_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == sops_pkg::REG_GAP_PARTIAL) begin
        gap_part_r <= cfg_wdata;
      end
      lfreq_r     <= lfreq_nxt;
      gfreq_r     <= gfreq_nxt;
      self_r      <= self_nxt;
      acc_r       <= acc_nxt;
      total_r     <= total_nxt;
      self_mode_r <= self_mode_nxt;
      gap_mode_r  <= gap_mode_nxt;
      diag_r      <= diag_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      eoc_r       <= eoc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    term_r     <= term_nxt;
    w_r        <= w_nxt;
    eoa_r      <= eoa_nxt;
    fi_r       <= fi_nxt;
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

  // The pair walk never leaves the lower triangle of the table.
  a_lower_tri: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= i_r) else $error("pair index above the diagonal");

  // Gap pass stays inside the four gap types.
  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    gap_mode_r |-> i_r <= LAST_GAP) else $error("gap row out of range");

  // The pair accumulator starts every column from zero.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sops_pkg::ST_IDLE |-> acc_r == '0) else $error("accumulator not cleared");

  // A result is only produced from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r) == sops_pkg::ST_OUT)
    else $error("result raised outside the output state");

endmodule

### rtl/core/sops_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sops_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/testbench.sv
// Self-checking bench for sum_of_pairs_alignment_score: loads the substitution table,
// streams weighted columns and compares every column score against a local predictor.
// Depends on sops_pkg and the RTL of the block.
`timescale 1ns / 1ps

class column_scoreboard;
  logic signed [15:0] table_q [20][20];
  logic [23:0]        lfreq [20];
  logic [23:0]        gfreq [4];
  longint             self_l, self_g, total;
  longint             g_open, g_part;
  longint             want_col [$];
  longint             want_half [$];
  bit                 want_fin [$];
  int                 errors;

  function new();
    clear_column();
    total = 0;
    g_open = -768;
    g_part = -154;
    errors = 0;
  endfunction

  function void clear_column();
    foreach (lfreq[i]) lfreq[i] = 0;
    foreach (gfreq[i]) gfreq[i] = 0;
    self_l = 0;
    self_g = 0;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint add48(longint a, longint b);
    return clamp(a + b, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
  endfunction

  // Unsigned product times a signed score, saturated to 48 bits.
  function longint mul48(longint unsigned p, longint m);
    longint unsigned mag;
    longint unsigned lim;
    longint r;
    lim = (64'd1 << 47) - 1;
    mag = m < 0 ? -m : m;
    if (p == 0 || mag == 0) return 0;
    if (p > lim / mag) return m < 0 ? -(64'sd1 <<< 47) : longint'(lim);
    r = longint'(p * mag);
    return m < 0 ? -r : r;
  endfunction

  function logic [23:0] sat_freq(logic [23:0] f, logic [15:0] w);
    logic [24:0] s;
    s = f + w;
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function longint gap_pen(int a, int b);
    int lo, hi;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    if ((lo == sops_pkg::GT_LL && hi == sops_pkg::GT_LG) ||
        (lo == sops_pkg::GT_LG && hi == sops_pkg::GT_GL)) return g_open;
    if (lo == sops_pkg::GT_LG && hi == sops_pkg::GT_GG) return g_part;
    return 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] v);
    if (idx == sops_pkg::REG_GAP_OPEN) g_open = longint'($signed(v));
    else g_part = longint'($signed(v));
  endfunction

  function void note_item(logic cmd, logic [55:0] d, logic eoc);
    logic [4:0] r, c, let_code;
    logic gh, gb;
    logic [15:0] w;
    int gt;
    longint acc, gacc, t, col, half;
    r = d[4:0]; c = d[9:5];
    let_code = d[30:26]; gh = d[31]; gb = d[32]; w = d[48:33];
    if (cmd == sops_pkg::CMD_LOAD) begin
      if (r < 20 && c < 20) begin
        table_q[r][c] = d[25:10];
      end
      return;
    end
    gt = gh + 2 * gb;
    gfreq[gt] = sat_freq(gfreq[gt], w);
    self_g = add48(self_g, mul48(longint'(w) * w, gap_pen(gt, gt)));
    if (!gh && let_code < 20) begin
      lfreq[let_code] = sat_freq(lfreq[let_code], w);
      self_l = add48(self_l, mul48(longint'(w) * w, table_q[let_code][let_code]));
    end
    if (!eoc) return;
    acc = 0;
    for (int i = 0; i < 20; i++) begin
      if (lfreq[i] == 0) continue;
      acc = add48(acc, mul48(longint'(lfreq[i]) * lfreq[i], table_q[i][i]));
      for (int j = 0; j < i; j++) begin
        t = mul48(longint'(lfreq[i]) * lfreq[j], table_q[i][j]);
        acc = add48(acc, t);
        acc = add48(acc, t);
      end
    end
    gacc = 0;
    for (int i = 0; i < 4; i++) begin
      if (gfreq[i] == 0) continue;
      gacc = add48(gacc, mul48(longint'(gfreq[i]) * gfreq[i], gap_pen(i, i)));
      for (int j = 0; j < i; j++) begin
        t = mul48(longint'(gfreq[i]) * gfreq[j], gap_pen(i, j));
        gacc = add48(gacc, t);
        gacc = add48(gacc, t);
      end
    end
    col = add48(acc, -self_l);
    col = add48(col, add48(gacc, -self_g));
    total = clamp(total + col, -(64'sd1 <<< 55), (64'sd1 <<< 55) - 1);
    half = clamp(total >>> 1, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    want_col.push_back(col);
    want_half.push_back(half);
    want_fin.push_back(d[49]);
    clear_column();
    if (d[49]) total = 0;
  endfunction

  function void check_result(logic [95:0] d, logic fin);
    logic [47:0] ec, eh;
    logic ef;
    if (want_col.size() == 0) begin
      $display("%0t: unexpected result %h", $time, d);
      errors++;
      return;
    end
    ec = 48'(want_col.pop_front());
    eh = 48'(want_half.pop_front());
    ef = want_fin.pop_front();
    if (d[47:0] !== ec) begin
      $display("%0t: column_score expected %h actual %h", $time, ec, d[47:0]);
      errors++;
    end
    if (d[95:48] !== eh) begin
      $display("%0t: half_total expected %h actual %h", $time, eh, d[95:48]);
      errors++;
    end
    if (fin !== ef) begin
      $display("%0t: final_res expected %b actual %b", $time, ef, fin);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  column_scoreboard scores;
  int  idle_cycles;
  int  burst_left;

  sum_of_pairs_alignment_score dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scores.check_result(out_tdata, out_tlast);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stalls in a rotating pattern, with stretches of constant readiness.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 200) % 3 == 0) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 9) > (phase % 7));
    end
  end

  task automatic send_item(logic cmd, logic [55:0] d, logic eoc);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 4)) begin
        in_tvalid <= 0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    in_tlast  <= eoc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scores.note_item(cmd, d, eoc);
    @(negedge clk);
  endtask

  task automatic load_entry(int r, int c, logic [15:0] v);
    logic [55:0] d;
    d = '0;
    d[4:0] = 5'(r); d[9:5] = 5'(c); d[25:10] = v;
    d[55:50] = 6'($urandom());
    send_item(sops_pkg::CMD_LOAD, d, 0);
  endtask

  task automatic seq_item(logic [4:0] l, logic gh, logic gb, logic [15:0] w,
                          logic eoc, logic eoa);
    logic [55:0] d;
    d = '0;
    d[4:0] = 5'($urandom()); d[9:5] = 5'($urandom()); d[25:10] = 16'($urandom());
    d[30:26] = l; d[31] = gh; d[32] = gb; d[48:33] = w; d[49] = eoa;
    send_item(sops_pkg::CMD_SEQ, d, eoc);
  endtask

  // Drains outstanding results, then writes a register while the block is idle.
  task automatic write_reg(logic [0:0] idx, logic [15:0] v);
    in_tvalid <= 0;
    while (scores.want_col.size() != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    scores.set_reg(idx, v);
  endtask

  task automatic random_weight(output logic [15:0] w);
    case ($urandom_range(0, 4))
      0: w = 16'hFFFF;
      1: w = 16'($urandom_range(0, 15));
      default: w = 16'($urandom());
    endcase
  endtask

  task automatic random_column(int depth, logic eoa);
    logic [15:0] w;
    logic [4:0] l;
    for (int k = 0; k < depth; k++) begin
      random_weight(w);
      l = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
      seq_item(l, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, w,
               k == depth - 1, (k == depth - 1) ? eoa : 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [15:0] regs [6];
    int sent;
    scores = new();
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // The whole table is written first so no read can hit an unloaded entry.
    for (int r = 0; r < 20; r++)
      for (int c = 0; c < 20; c++)
        load_entry(r, c, (r == 0 && c == 0) ? 16'h7FFF :
                         (r == 1 && c == 1) ? 16'h8000 : 16'($urandom()));
    // Directed: out-of-range loads, extreme weights, gap items, saturation, loose alignment end.
    load_entry(20, 3, 16'h1234);
    load_entry(31, 31, 16'hFFFF);
    seq_item(0, 0, 0, 16'hFFFF, 0, 1);
    seq_item(0, 0, 0, 16'hFFFF, 1, 0);
    seq_item(1, 0, 0, 16'hFFFF, 0, 0);
    seq_item(31, 1, 1, 16'hFFFF, 0, 0);
    seq_item(25, 0, 1, 16'h0000, 0, 0);
    seq_item(2, 1, 0, 16'h8000, 1, 1);
    for (int k = 0; k < 300; k++) seq_item(0, 0, 0, 16'hFFFF, 0, 0);
    seq_item(0, 0, 0, 16'hFFFF, 1, 0);
    seq_item(5, 1, 0, 16'hFFFF, 1, 1);
    sent = 0;

    regs = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        write_reg(sops_pkg::REG_GAP_OPEN, p == 3 ? 16'($urandom()) : regs[2 * (p - 1)]);
        write_reg(sops_pkg::REG_GAP_PARTIAL,
                  p == 3 ? 16'($urandom()) : regs[2 * (p - 1) + 1]);
      end
      while (sent < 160 * (p + 1)) begin
        int depth;
        depth = $urandom_range(1, 12);
        if ($urandom_range(0, 19) == 0) begin
          load_entry($urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom()));
          depth = 1;
        end else begin
          random_column(depth, $urandom_range(0, 4) == 0);
        end
        sent += depth;
      end
    end
    in_tvalid <= 0;
    while (scores.want_col.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (scores.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### sum_of_pairs_alignment_score.f
rtl/core/sops_pkg.sv
rtl/core/sops_ram.sv
rtl/core/sum_of_pairs_alignment_score.sv
bench/testbench.sv
